/* rtl/core/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// ecs_pkg
// Types, constants and helpers for the environmental sensor compensation.
// ----------------------------------------------------------------------------
package ecs_pkg;

	typedef struct packed {
		logic [23:0] raw_temp;
		logic [23:0] raw_press;
		logic [15:0] raw_hum;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temp_centi;
		logic               temp_valid;
		logic [31:0]        press_q24_8;
		logic               press_valid;
		logic [16:0]        hum_q22_10;
		logic               hum_valid;
	} out_t;

	// unpacked calibration coefficients, raw bits
	typedef struct packed {
		logic [15:0] t1, t2, t3;
		logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [7:0]  h6;
		logic [15:0] h4, h5;
	} cal_t;

	localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
	localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
	localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
	localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
	localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
	localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

	localparam logic [23:0] SKIP24  = 24'h800000;
	localparam logic [15:0] SKIP16  = 16'h8000;
	localparam logic [31:0] HUM_MAX = 32'd419430400;

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx8(input logic [7:0] v);
		return {{56{v[7]}}, v};
	endfunction

endpackage

/* rtl/core/ecs_mul.sv */
// ----------------------------------------------------------------------------
// ecs_mul
// Shared multiplier: low 64 bits of a 64 x 64 product, 16 bits of b a cycle.
// ----------------------------------------------------------------------------
module ecs_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  cnt_q;
	logic        run_q, done_q;
	logic [63:0] part;

	assign part = a_q * {48'b0, b_q[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + part;
			a_q   <= {a_q[47:0], 16'b0};
			b_q   <= {16'b0, b_q[63:16]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

/* rtl/core/ecs_div.sv */
// ----------------------------------------------------------------------------
// ecs_div
// Unsigned 64-bit restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ecs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [64:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = !diff[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/ecs_seq.sv */
// ----------------------------------------------------------------------------
// ecs_seq
// Sequencer: steps temperature, pressure and humidity through the shared units.
// ----------------------------------------------------------------------------
module ecs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ecs_pkg::in_t        item,
	input  ecs_pkg::cal_t       cal,
	input  logic                take,
	output logic                busy,
	output logic                fin,
	output ecs_pkg::out_t       res
);
	import ecs_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T0   = 5'd1;
	localparam logic [4:0] S_T1   = 5'd2;
	localparam logic [4:0] S_T2   = 5'd3;
	localparam logic [4:0] S_P0   = 5'd4;
	localparam logic [4:0] S_P1   = 5'd5;
	localparam logic [4:0] S_P2   = 5'd6;
	localparam logic [4:0] S_P3   = 5'd7;
	localparam logic [4:0] S_P4   = 5'd8;
	localparam logic [4:0] S_P5   = 5'd9;
	localparam logic [4:0] S_P6   = 5'd10;
	localparam logic [4:0] S_P7   = 5'd11;
	localparam logic [4:0] S_P8   = 5'd12;
	localparam logic [4:0] S_P9   = 5'd13;
	localparam logic [4:0] S_P10  = 5'd14;
	localparam logic [4:0] S_P11  = 5'd15;
	localparam logic [4:0] S_P12  = 5'd16;
	localparam logic [4:0] S_P13  = 5'd17;
	localparam logic [4:0] S_H0   = 5'd18;
	localparam logic [4:0] S_H1   = 5'd19;
	localparam logic [4:0] S_H2   = 5'd20;
	localparam logic [4:0] S_H3   = 5'd21;
	localparam logic [4:0] S_H4   = 5'd22;
	localparam logic [4:0] S_H5   = 5'd23;
	localparam logic [4:0] S_H6   = 5'd24;
	localparam logic [4:0] S_H7   = 5'd25;
	localparam logic [4:0] S_H8   = 5'd26;
	localparam logic [4:0] S_FIN  = 5'd27;

	logic [4:0]  st_q;
	logic        wait_q;
	logic [23:0] rt_q, rp_q;
	logic [15:0] rh_q;
	logic [31:0] fine_q;
	logic [63:0] r0_q, r1_q, r2_q, r3_q;
	out_t        res_q;

	logic        is_mul, is_div, go, mul_start, div_start, mul_done, div_done;
	logic [63:0] op_a, op_b, mp, dq;
	logic [63:0] ma, mb;
	logic [19:0] t_adc, p_adc;
	logic [31:0] f32, f5, hv32, hx32, v32;
	logic [63:0] psum, psh, pp;

	assign t_adc = rt_q[23:4];
	assign p_adc = rp_q[23:4];

	always_comb begin
		is_mul = st_q inside {S_T0, S_T1, S_T2, [S_P1:S_P6], S_P8, [S_P10:S_P12],
			[S_H1:S_H8]};
		is_div = (st_q == S_P9);
	end

	assign mul_start = is_mul && !wait_q;
	assign div_start = is_div && !wait_q;

	always_comb begin
		case (st_q)
			S_IDLE:  go = start;
			S_FIN:   go = take;
			default: go = is_mul ? mul_done : (is_div ? div_done : 1'b1);
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (st_q)
			S_T0: begin
				op_a = sx32({15'b0, t_adc[19:3]} - {15'b0, cal.t1, 1'b0});
				op_b = sx16(cal.t2);
			end
			S_T1: begin
				op_a = sx32({16'b0, t_adc[19:4]} - {16'b0, cal.t1});
				op_b = op_a;
			end
			S_T2:  begin op_a = r1_q; op_b = sx16(cal.t3); end
			S_P1:  begin op_a = r0_q; op_b = r0_q; end
			S_P2:  begin op_a = r1_q; op_b = sx16(cal.p6); end
			S_P3:  begin op_a = r0_q; op_b = sx16(cal.p5); end
			S_P4:  begin op_a = r1_q; op_b = sx16(cal.p3); end
			S_P5:  begin op_a = r0_q; op_b = sx16(cal.p2); end
			S_P6:  begin op_a = (64'd1 << 47) + r3_q; op_b = {48'b0, cal.p1}; end
			S_P8:  begin op_a = r1_q; op_b = 64'd3125; end
			S_P10: begin op_a = sx16(cal.p9); op_b = $signed(r0_q) >>> 13; end
			S_P11: begin op_a = r1_q; op_b = $signed(r0_q) >>> 13; end
			S_P12: begin op_a = sx16(cal.p8); op_b = r0_q; end
			S_H1:  begin op_a = sx16(cal.h5); op_b = r0_q; end
			S_H2:  begin op_a = r0_q; op_b = sx8(cal.h6); end
			S_H3:  begin op_a = r0_q; op_b = {56'b0, cal.h3}; end
			S_H4:  begin op_a = r2_q; op_b = r3_q; end
			S_H5:  begin op_a = r2_q; op_b = sx16(cal.h2); end
			S_H6:  begin op_a = r1_q; op_b = r2_q; end
			S_H7:  begin op_a = r2_q; op_b = r2_q; end
			S_H8:  begin op_a = r2_q; op_b = {56'b0, cal.h1}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// divide on magnitudes, sign restored afterwards
	assign ma = r1_q[63] ? (64'd0 - r1_q) : r1_q;
	assign mb = r3_q[63] ? (64'd0 - r3_q) : r3_q;

	ecs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mp)
	);

	ecs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ma),
		.den    (mb),
		.done   (div_done),
		.quo    (dq)
	);

	// fixed-function arithmetic around the shared units
	assign f32  = r0_q[31:0] + 32'($signed(sx32(mp[31:0])) >>> 14);
	assign f5   = {f32[29:0], 2'b0} + f32 + 32'd128;
	assign psum = r0_q + r1_q + r2_q;
	// arithmetic shift kept apart from the unsigned sum below
	assign psh  = $signed(psum) >>> 8;
	assign pp   = psh + (sx16(cal.p7) << 4);
	assign hv32 = {2'b0, rh_q, 14'b0} - {cal.h4[11:0], 20'b0} - mp[31:0] + 32'd16384;
	assign v32  = 32'($signed(sx32(mp[31:0])) >>> 4);
	assign hx32 = r3_q[31:0] - v32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			wait_q <= 1'b0;
			fine_q <= '0;
		end else begin
			if (go) begin
				wait_q <= 1'b0;
			end else if (mul_start || div_start) begin
				wait_q <= 1'b1;
			end
			if (go) begin
				case (st_q)
					S_IDLE:  st_q <= (item.raw_temp == SKIP24) ? S_P0 : S_T0;
					S_T2: begin
						fine_q <= f32;
						st_q   <= S_P0;
					end
					S_P0:    st_q <= (rp_q == SKIP24) ? S_H0 : S_P1;
					S_P7:    st_q <= (r3_q == '0) ? S_H0 : S_P8;
					S_P13:   st_q <= S_H0;
					S_H0:    st_q <= (rh_q == SKIP16) ? S_FIN : S_H1;
					S_H8:    st_q <= S_FIN;
					S_FIN:   st_q <= S_IDLE;
					default: st_q <= st_q + 5'd1;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (st_q)
				S_IDLE: begin
					rt_q  <= item.raw_temp;
					rp_q  <= item.raw_press;
					rh_q  <= item.raw_hum;
					res_q <= '0;
				end
				S_T0: r0_q <= $signed(sx32(mp[31:0])) >>> 11;
				S_T1: r1_q <= $signed(sx32(mp[31:0])) >>> 12;
				S_T2: begin
					res_q.temp_centi <= $signed(f5) >>> 8;
					res_q.temp_valid <= 1'b1;
				end
				S_P0: r0_q <= sx32(fine_q) - 64'd128000;
				S_P1: r1_q <= mp;
				S_P2: r2_q <= mp;
				S_P3: r2_q <= r2_q + (mp << 17) + (sx16(cal.p4) << 35);
				S_P4: r3_q <= $signed(mp) >>> 8;
				S_P5: r3_q <= r3_q + (mp << 12);
				S_P6: r3_q <= $signed(mp) >>> 33;
				S_P7: r1_q <= ((64'd1048576 - {44'b0, p_adc}) << 31) - r2_q;
				S_P8: r1_q <= mp;
				S_P9: r0_q <= (r1_q[63] ^ r3_q[63]) ? (64'd0 - dq) : dq;
				S_P10: r1_q <= mp;
				S_P11: r1_q <= $signed(mp) >>> 25;
				S_P12: r2_q <= $signed(mp) >>> 19;
				S_P13: begin
					if (pp[63]) begin
						res_q.press_q24_8 <= '0;
					end else if (|pp[62:32]) begin
						res_q.press_q24_8 <= '1;
					end else begin
						res_q.press_q24_8 <= pp[31:0];
					end
					res_q.press_valid <= 1'b1;
				end
				S_H0: r0_q <= sx32(fine_q - 32'd76800);
				S_H1: r1_q <= $signed(sx32(hv32)) >>> 15;
				S_H2: r2_q <= $signed(sx32(mp[31:0])) >>> 10;
				S_H3: r3_q <= sx32(32'($signed(sx32(mp[31:0])) >>> 11) + 32'd32768);
				S_H4: r2_q <= sx32(32'($signed(sx32(mp[31:0])) >>> 10) + 32'd2097152);
				S_H5: r2_q <= $signed(sx32(mp[31:0] + 32'd8192)) >>> 14;
				S_H6: begin
					r3_q <= sx32(mp[31:0]);
					r2_q <= $signed(sx32(mp[31:0])) >>> 15;
				end
				S_H7: r2_q <= $signed(sx32(mp[31:0])) >>> 7;
				S_H8: begin
					if (hx32[31]) begin
						res_q.hum_q22_10 <= '0;
					end else if (hx32 > HUM_MAX) begin
						res_q.hum_q22_10 <= HUM_MAX[28:12];
					end else begin
						res_q.hum_q22_10 <= hx32[28:12];
					end
					res_q.hum_valid <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign fin  = (st_q == S_FIN);
	assign res  = res_q;

endmodule

/* rtl/core/env_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity words.
// ----------------------------------------------------------------------------
// One item at a time: in_stall stays high from the accepted transfer until
// the result has moved to the output register. With all three words present
// and a nonzero pressure divisor an item makes 21 passes through the shared
// multiplier (64 x 16 bits a cycle), one serial divide for pressure and five
// further steps; the next input transfer can follow once the sequencer is
// back in idle. Skipped words shorten an item's run. While the output
// register is full and stalled the finished result waits in the sequencer,
// which keeps in_stall high. The configuration port is always ready; write
// the registers only while the block is idle.
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ecs_pkg::in_t        in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ecs_pkg::out_t       out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import ecs_pkg::*;

	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q, press_b_q;
	logic [15:0] press_c_q;
	logic [39:0] hum_a_q;
	logic [31:0] hum_b_q;
	cal_t        cal;
	logic        busy, fin, take, ov_q;
	out_t        res, od_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q  <= '0;
			press_b_q  <= '0;
			press_c_q  <= '0;
			hum_a_q    <= '0;
			hum_b_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP_CAL:    temp_cal_q <= cfg_data[47:0];
				REG_PRESS_CAL_A: press_a_q  <= cfg_data;
				REG_PRESS_CAL_B: press_b_q  <= cfg_data;
				REG_PRESS_CAL_C: press_c_q  <= cfg_data[15:0];
				REG_HUM_CAL_A:   hum_a_q    <= cfg_data[39:0];
				REG_HUM_CAL_B:   hum_b_q    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cal.t1 = temp_cal_q[15:0];
		cal.t2 = temp_cal_q[31:16];
		cal.t3 = temp_cal_q[47:32];
		cal.p1 = press_a_q[15:0];
		cal.p2 = press_a_q[31:16];
		cal.p3 = press_a_q[47:32];
		cal.p4 = press_a_q[63:48];
		cal.p5 = press_b_q[15:0];
		cal.p6 = press_b_q[31:16];
		cal.p7 = press_b_q[47:32];
		cal.p8 = press_b_q[63:48];
		cal.p9 = press_c_q;
		cal.h1 = hum_a_q[7:0];
		cal.h2 = hum_a_q[23:8];
		cal.h3 = hum_a_q[31:24];
		cal.h6 = hum_a_q[39:32];
		cal.h4 = hum_b_q[15:0];
		cal.h5 = hum_b_q[31:16];
	end

	assign in_stall = busy;
	assign take     = fin && (!ov_q || !out_stall);

	ecs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && !busy),
		.item   (in_data),
		.cal    (cal),
		.take   (take),
		.busy   (busy),
		.fin    (fin),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (take) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			od_q <= res;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

`ifndef SYNTHESIS
	// a transfer in always starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> busy)
		else $error("sequencer did not start after input transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hum_q22_10 <= 17'd102400))
		else $error("humidity out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.press_valid) |-> (out_data.press_q24_8 == '0))
		else $error("invalid pressure not zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.temp_valid) |-> (out_data.temp_centi == '0))
		else $error("invalid temperature not zero");

	// a result is only loaded into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!ov_q || !out_stall))
		else $error("result overwrote a pending transfer");
`endif

endmodule

/* sim/tb_env_sensor_compensation.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Drives raw sensor word sets through the compensation block under several
// calibration settings and idle patterns, predicts each compensated result in
// a scoreboard and compares the outputs field by field.
// ----------------------------------------------------------------------------
import ecs_pkg::*;

class comp_scoreboard;
	logic [63:0] cal [6];
	logic [31:0] fine_temp;
	out_t        expected_q [$];
	int          errors;

	function new();
		foreach (cal[i]) cal[i] = '0;
		fine_temp = '0;
		errors = 0;
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function void write_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			REG_TEMP_CAL:    cal[0] = val & 64'hFFFF_FFFF_FFFF;
			REG_PRESS_CAL_A: cal[1] = val;
			REG_PRESS_CAL_B: cal[2] = val;
			REG_PRESS_CAL_C: cal[3] = val & 64'hFFFF;
			REG_HUM_CAL_A:   cal[4] = val & 64'hFF_FFFF_FFFF;
			REG_HUM_CAL_B:   cal[5] = val & 64'hFFFF_FFFF;
			default: ;
		endcase
	endfunction

	function logic [31:0] asr32(logic [31:0] v, int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function logic [63:0] asr64(logic [63:0] v, int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function logic [31:0] s16to32(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function logic [63:0] s16to64(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// signed divide truncating toward zero, divisor nonzero
	function logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function void note(in_t d);
		out_t r;
		logic [31:0] adc, t1, t2, t3, tv1, tv2, d32;
		logic [63:0] padc, p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
		logic [31:0] rh, h1, h2, h3, h4, h5, h6, x, a, b, c, s;
		r = '0;
		if (d.raw_temp != SKIP24) begin
			adc = {8'd0, d.raw_temp} >> 4;
			t1 = {16'd0, cal[0][15:0]};
			t2 = s16to32(cal[0][31:16]);
			t3 = s16to32(cal[0][47:32]);
			tv1 = ((adc >> 3) - (t1 << 1)) * t2;
			tv1 = asr32(tv1, 11);
			d32 = (adc >> 4) - t1;
			tv2 = d32 * d32;
			tv2 = asr32(tv2, 12) * t3;
			tv2 = asr32(tv2, 14);
			fine_temp = tv1 + tv2;
			tv1 = fine_temp * 32'd5 + 32'd128;
			r.temp_centi = asr32(tv1, 8);
			r.temp_valid = 1'b1;
		end
		if (d.raw_press != SKIP24) begin
			padc = {40'd0, d.raw_press} >> 4;
			p1 = {48'd0, cal[1][15:0]};
			p2 = s16to64(cal[1][31:16]);
			p3 = s16to64(cal[1][47:32]);
			p4 = s16to64(cal[1][63:48]);
			p5 = s16to64(cal[2][15:0]);
			p6 = s16to64(cal[2][31:16]);
			p7 = s16to64(cal[2][47:32]);
			p8 = s16to64(cal[2][63:48]);
			p9 = s16to64(cal[3][15:0]);
			v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
			v2 = v1 * v1 * p6;
			v2 = v2 + ((v1 * p5) << 17);
			v2 = v2 + (p4 << 35);
			p = v1 * v1 * p3;
			v1 = asr64(p, 8) + ((v1 * p2) << 12);
			p = ((64'd1 << 47) + v1) * p1;
			v1 = asr64(p, 33);
			if (v1 != 0) begin
				p = 64'd1048576 - padc;
				p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
				v1 = p9 * asr64(p, 13) * asr64(p, 13);
				v1 = asr64(v1, 25);
				v2 = asr64(p8 * p, 19);
				p = asr64(p + v1 + v2, 8) + (p7 << 4);
				if (p[63])
					r.press_q24_8 = '0;
				else if (p > 64'hFFFF_FFFF)
					r.press_q24_8 = 32'hFFFF_FFFF;
				else
					r.press_q24_8 = p[31:0];
				r.press_valid = 1'b1;
			end
		end
		if (d.raw_hum != SKIP16) begin
			rh = {16'd0, d.raw_hum};
			h1 = {24'd0, cal[4][7:0]};
			h2 = s16to32(cal[4][23:8]);
			h3 = {24'd0, cal[4][31:24]};
			h6 = {{24{cal[4][39]}}, cal[4][39:32]};
			h4 = s16to32(cal[5][15:0]);
			h5 = s16to32(cal[5][31:16]);
			x = fine_temp - 32'd76800;
			a = (rh << 14) - (h4 << 20) - (h5 * x) + 32'd16384;
			a = asr32(a, 15);
			b = asr32(x * h3, 11) + 32'd32768;
			b = asr32(x * h6, 10) * b;
			b = asr32(b, 10) + 32'd2097152;
			c = b * h2 + 32'd8192;
			c = asr32(c, 14);
			x = a * c;
			s = asr32(x, 15);
			s = asr32(s * s, 7) * h1;
			x = x - asr32(s, 4);
			if (x[31]) x = '0;
			if (x > HUM_MAX) x = HUM_MAX;
			r.hum_q22_10 = x[28:12];
			r.hum_valid = 1'b1;
		end
		expected_q.push_back(r);
	endfunction

	task check(out_t got);
		out_t e;
		if (expected_q.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = expected_q.pop_front();
		if (got.temp_centi !== e.temp_centi)
			report($sformatf("temp_centi %0d, want %0d", got.temp_centi, e.temp_centi));
		if (got.temp_valid !== e.temp_valid)
			report($sformatf("temp_valid %b, want %b", got.temp_valid, e.temp_valid));
		if (got.press_q24_8 !== e.press_q24_8)
			report($sformatf("press_q24_8 %h, want %h", got.press_q24_8, e.press_q24_8));
		if (got.press_valid !== e.press_valid)
			report($sformatf("press_valid %b, want %b", got.press_valid, e.press_valid));
		if (got.hum_q22_10 !== e.hum_q22_10)
			report($sformatf("hum_q22_10 %0d, want %0d", got.hum_q22_10, e.hum_q22_10));
		if (got.hum_valid !== e.hum_valid)
			report($sformatf("hum_valid %b, want %b", got.hum_valid, e.hum_valid));
	endtask
endclass

module tb_env_sensor_compensation;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int         STALL_LIMIT  = 5000;
	localparam int         ITEMS_PER_PHASE = 210;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	comp_scoreboard sb;
	int tx_idle_pct;
	int rx_stall_pct;
	int quiet_cycles;

	env_sensor_compensation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_env_sensor_compensation NOT OK");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge with valid left high
	task cfg_write(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task send_item(in_t d);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (in_stall);
		sb.note(d);
		@(negedge clk);
	endtask

	task drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// calibration sets: typical part, all ones, sign extremes, then random
	task load_cal(int set_no);
		logic [63:0] v [6];
		case (set_no)
			0: begin
				v[0] = 64'({16'hFC18, 16'd26435, 16'd27504});
				v[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
				v[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
				v[3] = 64'd6000;
				v[4] = 64'({8'd30, 8'd0, 16'd362, 8'd75});
				v[5] = 64'({16'd50, 16'd313});
			end
			1: foreach (v[i]) v[i] = '1;
			2: foreach (v[i]) v[i] = {4{16'h8000}};
			3: foreach (v[i]) v[i] = {4{16'h7FFF}};
			default: foreach (v[i]) v[i] = rand64();
		endcase
		cfg_write(REG_TEMP_CAL,    v[0]);
		cfg_write(REG_PRESS_CAL_A, v[1]);
		cfg_write(REG_PRESS_CAL_B, v[2]);
		cfg_write(REG_PRESS_CAL_C, v[3]);
		cfg_write(REG_HUM_CAL_A,   v[4]);
		cfg_write(REG_HUM_CAL_B,   v[5]);
		cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, rand64());
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function in_t rand_item();
		in_t d;
		d.raw_temp  = ($urandom_range(7) == 0) ? SKIP24 : 24'($urandom);
		d.raw_press = ($urandom_range(7) == 0) ? SKIP24 : 24'($urandom);
		d.raw_hum   = ($urandom_range(7) == 0) ? SKIP16 : 16'($urandom);
		// a share of plausible readings keeps the outputs in their usual range
		if ($urandom_range(2) == 0) begin
			d.raw_temp  = 24'($urandom_range(24'h9FFFF0, 24'h5FFFF0));
			d.raw_press = 24'($urandom_range(24'h6FFFF0, 24'h3FFFF0));
			d.raw_hum   = 16'($urandom_range(16'h9000, 16'h4000));
		end
		return d;
	endfunction

	initial begin
		in_t d;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset calibration: pressure divisor is zero
		send_item('{24'h519880, 24'h415140, 16'h6F00});
		send_item('{SKIP24, SKIP24, SKIP16});
		drain();
		load_cal(0);
		send_item('{24'h519880, 24'h415140, 16'h6F00});
		send_item('{SKIP24, 24'h415140, 16'h6F00});
		send_item('{24'h519880, SKIP24, 16'h6F00});
		send_item('{24'h519880, 24'h415140, SKIP16});
		send_item('{24'h000000, 24'h000000, 16'h0000});
		send_item('{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF});
		send_item('{24'h800001, 24'h7FFFFF, 16'h8001});
		send_item('{24'h7FFFFF, 24'h800001, 16'h7FFF});
		send_item('{24'h00000F, 24'hFFFFF0, 16'h0001});
		send_item('{SKIP24, SKIP24, SKIP16});
		send_item('{24'h800000, 24'h000010, 16'hFFFE});

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			repeat (8) @(negedge clk);
			load_cal(ph);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
				default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off until the block is empty, once midway through each phase
				if (n == ITEMS_PER_PHASE / 2)
					drain();
				d = rand_item();
				send_item(d);
			end
		end
		drain();
		repeat (300) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
		if (sb.errors == 0)
			$display("tb_env_sensor_compensation OK");
		else
			$display("tb_env_sensor_compensation NOT OK");
		$finish;
	end
endmodule
